/* rtl/sbcd_pkg.sv */
`default_nettype none

package sbcd_pkg;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int COUNT_W     = 16;
    localparam int SDEPTH_W    = 15;
    localparam int DEPTH_W     = 21;
    localparam int VEL_W       = 16;
    localparam int THR_W       = 20;

    localparam logic [CFG_ADDR_W-1:0] REG_SURFACE_DEPTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BOTTOM_TRIGGER = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SURFACE_TRIGGER = 2'd2;

    localparam logic signed [SDEPTH_W-1:0] SURFACE_DEPTH_RST = -15'sd10;
    localparam logic [COUNT_W-1:0]         BOTTOM_TRIGGER_RST = 16'd400;
    localparam logic [COUNT_W-1:0]         SURFACE_TRIGGER_RST = 16'd400;

    // stationary band (mm/s, strict) and surface hysteresis (mm)
    localparam logic signed [VEL_W-1:0] STILL_MM_S = 16'sd50;
    localparam logic signed [THR_W-1:0] HYST_MM    = 20'sd50;

    typedef struct packed {
        logic                      lim_lower;
        logic                      lim_upper;
        logic signed [VEL_W-1:0]   vertical_velocity;
        logic signed [DEPTH_W-1:0] depth_mm;
        logic                      depth_valid;
        logic                      armed;
    } item_t;

    typedef struct packed {
        logic                bottom_changed;
        logic                surface_changed;
        logic                bot_now;
        logic                surf_now;
    } result_t;

    typedef struct packed {
        logic               surfaced;
        logic               bottomed;
        logic [COUNT_W-1:0] bottom_count;
        logic [COUNT_W-1:0] surface_count;
    } state_t;

    typedef struct packed {
        logic signed [SDEPTH_W-1:0] surface_depth_cm;
        logic [COUNT_W-1:0]         bottom_trigger_ticks;
        logic [COUNT_W-1:0]         surface_trigger_ticks;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/sbcd_core.sv */
`default_nettype none

module sbcd_core (
    input  var sbcd_pkg::state_t  state,
    input  var sbcd_pkg::cfg_t    cfg,
    input  var sbcd_pkg::item_t   item,
    output var sbcd_pkg::state_t  state_next,
    output var sbcd_pkg::result_t result
);
    import sbcd_pkg::*;

    logic                     still;
    logic signed [THR_W-1:0]  cm_ext;
    logic signed [THR_W-1:0]  thr;
    logic                     above;
    logic                     surf_n;
    logic                     bot_n;
    logic [COUNT_W-1:0]       bcnt_n;
    logic [COUNT_W-1:0]       scnt_n;

    assign still = (item.vertical_velocity > -STILL_MM_S) &&
                   (item.vertical_velocity < STILL_MM_S);

    // threshold = cm * 10, less hysteresis while surfaced
    assign cm_ext = THR_W'(cfg.surface_depth_cm);
    always_comb begin
        thr = (cm_ext <<< 3) + (cm_ext <<< 1);
        if (state.surfaced) begin
            thr = thr - HYST_MM;
        end
    end

    assign above = $signed({item.depth_mm[DEPTH_W-1], item.depth_mm}) >
                   $signed({{(DEPTH_W+1-THR_W){thr[THR_W-1]}}, thr});

    always_comb begin
        surf_n = state.surfaced;
        bot_n  = state.bottomed;
        bcnt_n = state.bottom_count;
        scnt_n = state.surface_count;
        if (!item.armed) begin
            surf_n = 1'b0;
            bot_n  = 1'b0;
        end else if (item.depth_valid) begin
            surf_n = above;
            if (item.lim_lower && still) begin
                if (state.bottom_count < cfg.bottom_trigger_ticks) begin
                    bcnt_n = state.bottom_count + 1'b1;
                end else begin
                    bot_n = 1'b1;
                end
            end else begin
                bot_n = 1'b0;
            end
        end else if (still) begin
            if (item.lim_upper) begin
                if (state.surface_count < cfg.surface_trigger_ticks) begin
                    scnt_n = state.surface_count + 1'b1;
                end else begin
                    surf_n = 1'b1;
                end
            end else if (item.lim_lower) begin
                if (state.bottom_count < cfg.bottom_trigger_ticks) begin
                    bcnt_n = state.bottom_count + 1'b1;
                end else begin
                    bot_n = 1'b1;
                end
            end else begin
                surf_n = 1'b0;
                bot_n  = 1'b0;
            end
        end else begin
            surf_n = 1'b0;
            bot_n  = 1'b0;
        end
        // a flag change restarts its debounce
        if (surf_n != state.surfaced) begin
            scnt_n = '0;
        end
        if (bot_n != state.bottomed) begin
            bcnt_n = '0;
        end
    end

    assign state_next = '{surfaced: surf_n, bottomed: bot_n,
                          bottom_count: bcnt_n, surface_count: scnt_n};

    assign result = '{bottom_changed: bot_n != state.bottomed,
                      surface_changed: surf_n != state.surfaced,
                      bot_now: bot_n, surf_now: surf_n};

endmodule

`default_nettype wire

/* rtl/surface_bottom_contact_detector.sv */
// Surface and bottom contact detector.
// s_* channel: one control-loop tick per request; s_tdata holds, from bit 0:
//   armed, depth_valid, depth_mm[20:0], vertical_velocity[15:0],
//   upper throttle limit, lower throttle limit, zero fill to 48 bits.
// m_* channel: one result per tick; m_tdata holds, from bit 0:
//   surfaced flag, bottomed flag, surface_changed, bottom_changed, zero fill.
// cfg_*: register writes (0 surface_depth_cm, 1 bottom_trigger_ticks,
//   2 surface_trigger_ticks); cfg_ready is always high, index 3 is ignored.
//   Write only while no tick is in flight.
// Path: from input accept to m_tvalid, the input register feeds the update and
//   the result register catches it once the output has room.
//   Throughput: one tick per cycle while the output is not stalled, set by the single
//   flag/counter update between the two registers.
// Reset (aresetn low, synchronous): flags and counters clear, registers take
//   their defaults, both channels empty.
// When m_tready is low the result holds; one more request is taken into the
//   input register, then s_tready drops until the result drains.
`default_nettype none

module surface_bottom_contact_detector (
    input  var logic                                aclk,
    input  var logic                                aresetn,
    input  var logic                                s_tvalid,
    output var logic                                s_tready,
    // armed, depth_valid, depth_mm, vertical_velocity, lim_upper, lim_lower
    input  var logic [sbcd_pkg::IN_TDATA_W-1:0]     s_tdata,
    output var logic                                m_tvalid,
    input  var logic                                m_tready,
    // surf_now, bot_now, surface_changed, bottom_changed
    output var logic [sbcd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  var logic                                cfg_valid,
    output var logic                                cfg_ready,
    input  var logic [sbcd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  var logic [sbcd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import sbcd_pkg::*;

    logic    in_valid_reg;
    item_t   in_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    cfg_t    cfg_reg;
    logic    move;

    assign move      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || move;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_TDATA_W'(out_data_reg);

    sbcd_core u_core (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .item       (in_data_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (move) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            out_data_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (move) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.surface_depth_cm      <= SURFACE_DEPTH_RST;
            cfg_reg.bottom_trigger_ticks  <= BOTTOM_TRIGGER_RST;
            cfg_reg.surface_trigger_ticks <= SURFACE_TRIGGER_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                REG_SURFACE_DEPTH: begin
                    cfg_reg.surface_depth_cm <= cfg_wdata[SDEPTH_W-1:0];
                end
                REG_BOTTOM_TRIGGER: begin
                    cfg_reg.bottom_trigger_ticks <= cfg_wdata;
                end
                REG_SURFACE_TRIGGER: begin
                    cfg_reg.surface_trigger_ticks <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_state_only_on_move: assert property (@(posedge aclk) disable iff (!aresetn)
        !move |=> $stable(state_reg))
        else $error("state changed without a tick");

    a_disarm_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        move && !in_data_reg.armed |=> !state_reg.surfaced && !state_reg.bottomed)
        else $error("disarmed tick left a flag set");

    a_bcount_step: assert property (@(posedge aclk) disable iff (!aresetn)
        move |=> (state_reg.bottom_count == '0) ||
                 $stable(state_reg.bottom_count) ||
                 (state_reg.bottom_count == $past(state_reg.bottom_count) + 1'b1))
        else $error("bottom count jumped");

    a_change_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        move && result_next.surface_changed |=> state_reg.surface_count == '0)
        else $error("surface change did not restart count");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        move |=> out_valid_reg)
        else $error("tick produced no result");
`endif

endmodule

`default_nettype wire

/* sim/surface_bottom_contact_detector_tb.sv */
`default_nettype none

module surface_bottom_contact_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbcd_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam int ITEM_W = $bits(item_t);
    localparam int RESULT_W = $bits(result_t);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS = 10;

    // Tracks surfaced/bottomed flags and debounce counts, queues the flags each tick must yield.
    class contact_tracker;
        result_t flags_due[$];
        logic signed [SDEPTH_W-1:0] depth_thr_cm;
        logic [COUNT_W-1:0] bottom_trig;
        logic [COUNT_W-1:0] surface_trig;
        logic [COUNT_W-1:0] bottom_cnt;
        logic [COUNT_W-1:0] surface_cnt;
        bit surfaced;
        bit bottomed;
        int failures;

        function new();
            depth_thr_cm = SURFACE_DEPTH_RST;
            bottom_trig = BOTTOM_TRIGGER_RST;
            surface_trig = SURFACE_TRIGGER_RST;
            bottom_cnt = '0;
            surface_cnt = '0;
            surfaced = 1'b0;
            bottomed = 1'b0;
            failures = 0;
        endfunction

        function void flag_error(string msg);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%t: %s", $realtime, msg);
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SURFACE_DEPTH: depth_thr_cm = data[SDEPTH_W-1:0];
                REG_BOTTOM_TRIGGER: bottom_trig = data;
                REG_SURFACE_TRIGGER: surface_trig = data;
                default: ;
            endcase
        endfunction

        function void set_surface(bit s);
            if (surfaced != s) begin
                surfaced = s;
                surface_cnt = '0;
            end
        endfunction

        function void set_bottom(bit b);
            if (bottomed != b) begin
                bottomed = b;
                bottom_cnt = '0;
            end
        endfunction

        function void bump_bottom();
            if (bottom_cnt < bottom_trig)
                bottom_cnt++;
            else
                set_bottom(1'b1);
        endfunction

        function void log_tick(item_t it);
            bit s0;
            bit b0;
            bit still;
            int vel;
            int depth;
            int thr;
            result_t r;
            s0 = surfaced;
            b0 = bottomed;
            vel = int'($signed(it.vertical_velocity));
            depth = int'($signed(it.depth_mm));
            still = (vel > -50) && (vel < 50);
            if (!it.armed) begin
                set_surface(1'b0);
                set_bottom(1'b0);
            end else if (it.depth_valid) begin
                thr = int'($signed(depth_thr_cm)) * 10;
                if (surfaced)
                    thr -= 50;
                set_surface(depth > thr);
                if (it.lim_lower && still)
                    bump_bottom();
                else
                    set_bottom(1'b0);
            end else if (still && it.lim_upper) begin
                if (surface_cnt < surface_trig)
                    surface_cnt++;
                else
                    set_surface(1'b1);
            end else if (still && it.lim_lower) begin
                bump_bottom();
            end else begin
                set_surface(1'b0);
                set_bottom(1'b0);
            end
            r.surf_now = surfaced;
            r.bot_now = bottomed;
            r.surface_changed = surfaced != s0;
            r.bottom_changed = bottomed != b0;
            flags_due.push_back(r);
        endfunction

        function void match_flags(result_t got);
            result_t want;
            if (flags_due.size() == 0) begin
                flag_error($sformatf("unexpected result %b", got));
                return;
            end
            want = flags_due.pop_front();
            if (got.surf_now !== want.surf_now || got.bot_now !== want.bot_now ||
                got.surface_changed !== want.surface_changed ||
                got.bottom_changed !== want.bottom_changed)
                flag_error($sformatf(
                    "want surf=%b bot=%b dsurf=%b dbot=%b, got surf=%b bot=%b dsurf=%b dbot=%b",
                    want.surf_now, want.bot_now, want.surface_changed, want.bottom_changed,
                    got.surf_now, got.bot_now, got.surface_changed, got.bottom_changed));
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    contact_tracker tracker = new();
    bit send_quiet = 1'b0;
    bit sink_quiet = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;
    int cur_depth_cm = -10;

    surface_bottom_contact_detector u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5ns aclk = ~aclk;

    // result sink with random stalls
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!sink_quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                       : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
        if ($urandom_range(0, 149) == 0)
            sink_quiet <= !sink_quiet;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_addr, cfg_wdata);
            if (s_tvalid && s_tready)
                tracker.log_tick(item_t'(s_tdata[ITEM_W-1:0]));
            if (m_tvalid && m_tready)
                tracker.match_flags(result_t'(m_tdata[RESULT_W-1:0]));
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("surface_bottom_contact_detector verification failed");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (send_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic item_t mk(bit armed, bit dv, int depth, int vel, bit up, bit low);
        item_t it;
        it.armed = armed;
        it.depth_valid = dv;
        it.depth_mm = DEPTH_W'(depth);
        it.vertical_velocity = VEL_W'(vel);
        it.lim_upper = up;
        it.lim_lower = low;
        return it;
    endfunction

    task automatic send_tick(input item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_TDATA_W - ITEM_W){1'b0}}, it};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic push_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_regs(input logic [CFG_DATA_W-1:0] depth_word,
                             input logic [CFG_DATA_W-1:0] bt, input logic [CFG_DATA_W-1:0] st);
        push_reg(REG_SURFACE_DEPTH, depth_word);
        push_reg(REG_BOTTOM_TRIGGER, bt);
        push_reg(REG_SURFACE_TRIGGER, st);
        push_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
        cfg_valid <= 1'b0;
        cur_depth_cm = int'($signed(depth_word[SDEPTH_W-1:0]));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.flags_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input int n);
        int left;
        int len;
        int kind;
        logic [63:0] raw;
        item_t it;
        left = n;
        while (left > 0) begin
            kind = $urandom_range(0, 9);
            len = (kind == 9) ? $urandom_range(1, 4) : $urandom_range(2, 30);
            send_quiet = ($urandom_range(0, 3) == 0);
            repeat (len) begin
                raw = {$urandom(), $urandom()};
                it = raw[ITEM_W-1:0];
                case (kind)
                    0, 1, 2: begin
                        // hover around the surface threshold
                        it.armed = 1'b1;
                        it.depth_valid = 1'b1;
                        it.depth_mm = DEPTH_W'(cur_depth_cm * 10 +
                                               int'($urandom_range(0, 240)) - 120);
                        it.vertical_velocity = VEL_W'(int'($urandom_range(0, 98)) - 49);
                    end
                    3, 4: begin
                        it.armed = 1'b1;
                        it.depth_valid = 1'($urandom_range(0, 1));
                        it.lim_upper = 1'b0;
                        it.lim_lower = 1'b1;
                        it.vertical_velocity = VEL_W'(int'($urandom_range(0, 98)) - 49);
                    end
                    5, 6: begin
                        it.armed = 1'b1;
                        it.depth_valid = 1'b0;
                        it.lim_upper = 1'b1;
                        it.vertical_velocity = VEL_W'(int'($urandom_range(0, 98)) - 49);
                    end
                    7: begin
                        it.armed = 1'b1;
                        case ($urandom_range(0, 3))
                            0: it.vertical_velocity = -16'sd50;
                            1: it.vertical_velocity = -16'sd49;
                            2: it.vertical_velocity = 16'sd49;
                            default: it.vertical_velocity = 16'sd50;
                        endcase
                    end
                    8: ;
                    default: it.armed = 1'b0;
                endcase
                if ($urandom_range(0, 19) == 0)
                    it.vertical_velocity = raw[63:48];
                send_tick(it);
                left--;
            end
        end
        send_quiet = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // threshold -100 mm, short debounce
        load_regs(-16'sd10, 16'd2, 16'd1);
        send_tick(mk(0, 1, -1, -1, 1, 1));
        send_tick(mk(1, 1, -99, 0, 0, 0));
        send_tick(mk(1, 1, -149, 0, 0, 0));
        send_tick(mk(1, 1, -150, 0, 0, 0));
        send_tick(mk(1, 1, -100, 0, 0, 0));
        send_tick(mk(1, 1, 1048575, 0, 0, 0));
        send_tick(mk(1, 1, -1048576, 0, 0, 0));
        repeat (3) send_tick(mk(1, 1, -1048576, 49, 0, 1));
        send_tick(mk(1, 1, -1048576, 50, 0, 1));
        send_tick(mk(1, 1, -5000, -49, 1, 1));
        send_tick(mk(1, 1, -5000, -50, 0, 1));
        repeat (2) send_tick(mk(1, 1, -5000, 0, 0, 1));
        send_tick(mk(1, 0, 0, 0, 1, 0));
        send_tick(mk(1, 0, 0, 0, 1, 1));
        send_tick(mk(1, 0, 0, 0, 0, 0));
        send_tick(mk(1, 0, 0, 32767, 1, 1));
        send_tick(mk(1, 0, 0, -32768, 1, 1));
        send_tick(mk(1, 0, 0, 10, 0, 1));
        send_tick(mk(0, 0, 0, 0, 0, 0));
        drain();

        load_regs(-16'sd10, 16'd0, 16'd0);
        run_phase(120);
        drain();

        // bit 15 of the depth word is dropped: threshold -16384 cm
        load_regs(16'hC000, 16'd30, 16'd25);
        run_phase(120);
        drain();

        // triggers lowered below counts left by the previous setting
        load_regs(16'd0, 16'd3, 16'd5);
        run_phase(120);
        drain();

        load_regs(-16'sd10000, 16'hFFFF, 16'hFFFF);
        run_phase(100);
        drain();

        load_regs(CFG_DATA_W'(-int'($urandom_range(0, 10000))),
                  CFG_DATA_W'($urandom_range(0, 20)), CFG_DATA_W'($urandom_range(0, 20)));
        run_phase(150);
        drain();

        load_regs(16'h3FFF, 16'd1, 16'd2);
        run_phase(60);
        drain();

        load_regs(-16'sd10, 16'd400, 16'd400);
        run_phase(100);
        drain();

        if (tracker.flags_due.size() != 0)
            tracker.flag_error($sformatf("%0d results never arrived", tracker.flags_due.size()));
        if (tracker.failures == 0)
            $display("surface_bottom_contact_detector verification clean");
        else
            $display("surface_bottom_contact_detector verification failed");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/sbcd_pkg.sv
rtl/sbcd_core.sv
rtl/surface_bottom_contact_detector.sv
sim/surface_bottom_contact_detector_tb.sv
